### design/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes of the buddy sub-allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int LVL_W = 7;  // levels up to 64, with one step of headroom

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REALLOC = 2'd2,
        REQ_NONE    = 2'd3
    } bsa_kind_t;

    typedef enum logic [1:0] {
        NK_ABSENT = 2'd0,
        NK_INNER  = 2'd1,
        NK_FREE   = 2'd2,
        NK_BUSY   = 2'd3
    } bsa_node_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADOFF  = 2'd2,
        ST_UNUSED  = 2'd3
    } bsa_status_t;

    localparam logic REG_WHOLE = 1'b0;
    localparam logic REG_MIN   = 1'b1;

    localparam logic [5:0] WHOLE_RESET = 6'd20;
    localparam logic [5:0] MIN_RESET   = 6'd10;

    typedef struct packed {
        bsa_kind_t   kind;
        logic [31:0] block_offset;
        logic [32:0] request_size;
        logic [32:0] request_alignment;
    } bsa_req_t;

    typedef struct packed {
        logic [31:0] result_offset;
        bsa_status_t status;
    } bsa_rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        bsa_kind_t        kind;
        logic [31:0]      boff;
        logic             size_zero;
        logic [LVL_W-1:0] want;
    } bsa_item_t;

endpackage

### design/bsa_front.sv
// ----------------------------------------------------------------------------
// bsa_front
// Accept request beats, work out the request level, and queue them.
// ----------------------------------------------------------------------------
module bsa_front
    import bsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [5:0] bot_lv,
    input  logic       req_valid,
    output logic       req_stall,
    input  bsa_req_t   req,
    output logic       q_valid,
    output bsa_item_t  q_item,
    input  logic       q_pop
);

    bsa_item_t   ent_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    bsa_item_t   cls;
    logic [32:0] size_m1;
    logic [32:0] align_sh;
    logic [LVL_W-1:0] clg;
    logic [LVL_W-1:0] alg;
    logic [LVL_W-1:0] w;

    // bit length of size-1 and of align>>1
    always_comb
    begin
        size_m1  = req.request_size - 33'd1;
        align_sh = req.request_alignment >> 1;
        clg = '0;
        alg = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (size_m1[i])
                clg = LVL_W'(i + 1);
            if (align_sh[i])
                alg = LVL_W'(i + 1);
        end
        w = clg;
        if (w < {1'b0, bot_lv})
            w = {1'b0, bot_lv};
        if (w < alg)
            w = alg;
        cls.kind      = req.kind;
        cls.boff      = req.block_offset;
        cls.size_zero = (req.request_size == 33'd0);
        cls.want      = w;
    end

    assign req_stall = (cnt_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= cls;
    end

endmodule

### design/bsa_back.sv
// ----------------------------------------------------------------------------
// bsa_back
// Carry out queued requests on the node tree and the per-level free lists.
// ----------------------------------------------------------------------------
module bsa_back
    import bsa_pkg::*;
#(
    parameter int SPLIT_DEPTH = 10,
    parameter int OFFSET_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       restart,
    input  logic [5:0] top_lv,
    input  logic [5:0] bot_lv,
    input  logic       q_valid,
    input  bsa_item_t  q_item,
    output logic       q_pop,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output bsa_rsp_t   rsp
);

    localparam int NB = SPLIT_DEPTH + 1;
    localparam int SW = $clog2(SPLIT_DEPTH + 1);
    localparam int AW = (OFFSET_BITS > 32 ? OFFSET_BITS : 32) + 1;

    typedef enum logic [15:0] {
        S_CLR    = 16'h0001,
        S_IDLE   = 16'h0002,
        S_FB_RD  = 16'h0004,
        S_FB_CHK = 16'h0008,
        S_FR_RD  = 16'h0010,
        S_FR_CHK = 16'h0020,
        S_FR_MRG = 16'h0040,
        S_PUSH1  = 16'h0080,
        S_PUSH2  = 16'h0100,
        S_SRCH   = 16'h0200,
        S_LRD    = 16'h0400,
        S_RM     = 16'h0800,
        S_SP1    = 16'h1000,
        S_SP2    = 16'h2000,
        S_BUSY   = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    state_t           state_reg, state_next;
    logic [NB-1:0]    n_reg, n_next;
    logic [LVL_W-1:0] lv_reg, lv_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [NB-1:0]    h_reg, h_next;
    logic [NB-1:0]    r_reg, r_next;
    bsa_item_t        item_reg, item_next;
    logic [31:0]      roff_reg, roff_next;
    bsa_status_t      rstat_reg, rstat_next;
    logic [NB-1:0]    cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    bsa_rsp_t         out_reg, out_next;

    logic [1:0]       kind_mem [2**NB];
    logic [NB-1:0]    next_mem [2**NB];
    logic [NB-1:0]    prev_mem [2**NB];
    logic [1:0]       kind_rd_reg;
    logic [NB-1:0]    next_rd_reg, prev_rd_reg;
    logic [NB-1:0]    head_reg [SPLIT_DEPTH + 1];

    logic [NB-1:0]    kaddr, kwa, laddr, nwa, nwd, pwa, pwd, hwd, head_rd;
    logic [1:0]       kwd;
    logic             kwe, nwe, pwe, hwe, clr_init;
    logic [SW-1:0]    hidx;
    logic [AW-1:0]    half, split, off_ext, off_full;
    logic [LVL_W-1:0] top_x, bot_x, dpt;
    logic [NB-1:0]    sib, n_strip;

    function automatic logic [SW-1:0] slot_of(input logic [LVL_W-1:0] lv,
                                              input logic [LVL_W-1:0] bot);
        logic [LVL_W-1:0] s;
        s = lv - bot;
        if (lv < bot || s > LVL_W'(SPLIT_DEPTH))
            return SW'(SPLIT_DEPTH);
        return s[SW-1:0];
    endfunction

    assign top_x    = {1'b0, top_lv};
    assign bot_x    = {1'b0, bot_lv};
    assign hidx     = (state_reg == S_SP1) ? slot_of(lv_reg - 1'b1, bot_x)
                                           : slot_of(lv_reg, bot_x);
    assign head_rd  = head_reg[hidx];
    assign sib      = n_reg ^ NB'(1);
    assign half     = AW'(1) << (lv_reg - 1'b1);
    assign split    = base_reg + half;
    assign off_ext  = AW'(item_reg.boff);
    assign dpt      = top_x - lv_reg;
    assign n_strip  = n_reg & ~(NB'(1) << dpt);
    assign off_full = AW'(n_strip) << lv_reg;
    assign clr_init = (state_reg == S_CLR) && (cnt_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lv_next        = lv_reg;
        base_next      = base_reg;
        h_next         = h_reg;
        r_next         = r_reg;
        item_next      = item_reg;
        roff_next      = roff_reg;
        rstat_next     = rstat_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        q_pop = 1'b0;
        kaddr = n_reg;
        laddr = n_reg;
        kwe = 1'b0; kwa = n_reg; kwd = NK_ABSENT;
        nwe = 1'b0; nwa = n_reg; nwd = '0;
        pwe = 1'b0; pwa = n_reg; pwd = '0;
        hwe = 1'b0; hwd = '0;

        case (state_reg)
            S_CLR:
            begin
                // sweep the node kinds; root comes back as a free leaf
                kwe = 1'b1;
                kwa = cnt_reg;
                kwd = (cnt_reg == NB'(1)) ? NK_FREE : NK_ABSENT;
                if (cnt_reg == '0)
                begin
                    nwe = 1'b1; nwa = NB'(1);
                    pwe = 1'b1; pwa = NB'(1);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    roff_next  = '0;
                    rstat_next = ST_OK;
                    n_next     = NB'(1);
                    lv_next    = top_x;
                    base_next  = '0;
                    case (q_item.kind)
                        REQ_ALLOC:
                        begin
                            lv_next = q_item.want;
                            if (q_item.size_zero)
                            begin
                                rstat_next = ST_NOSPACE;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_SRCH;
                        end
                        REQ_FREE, REQ_REALLOC: state_next = S_FB_RD;
                        default:               state_next = S_DONE;
                    endcase
                end
            end
            S_FB_RD:
            begin
                state_next = S_FB_CHK;
            end
            S_FB_CHK:
            begin
                if (lv_reg > bot_x && kind_rd_reg == NK_INNER)
                begin
                    if (off_ext < split)
                        n_next = {n_reg[NB-2:0], 1'b0};
                    else
                    begin
                        base_next = split;
                        n_next    = {n_reg[NB-2:0], 1'b1};
                    end
                    lv_next    = lv_reg - 1'b1;
                    state_next = S_FB_RD;
                end
                else if (kind_rd_reg == NK_BUSY && base_reg == off_ext)
                begin
                    if (item_reg.kind == REQ_FREE)
                        state_next = S_FR_RD;
                    else if (item_reg.size_zero)
                    begin
                        rstat_next = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else if (lv_reg >= item_reg.want)
                    begin
                        roff_next  = item_reg.boff;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_FR_RD;
                end
                else
                begin
                    rstat_next = ST_BADOFF;
                    state_next = S_DONE;
                end
            end
            S_FR_RD:
            begin
                kaddr = sib;
                laddr = sib;
                state_next = (n_reg > NB'(1)) ? S_FR_CHK : S_PUSH1;
            end
            S_FR_CHK:
            begin
                if (kind_rd_reg == NK_FREE)
                begin
                    // unlink the buddy from its list
                    if (prev_rd_reg == '0)
                    begin
                        hwe = 1'b1;
                        hwd = next_rd_reg;
                    end
                    else
                    begin
                        nwe = 1'b1; nwa = prev_rd_reg; nwd = next_rd_reg;
                    end
                    if (next_rd_reg != '0)
                    begin
                        pwe = 1'b1; pwa = next_rd_reg; pwd = prev_rd_reg;
                    end
                    kwe = 1'b1; kwa = sib; kwd = NK_ABSENT;
                    state_next = S_FR_MRG;
                end
                else
                    state_next = S_PUSH1;
            end
            S_FR_MRG:
            begin
                kwe = 1'b1; kwa = n_reg; kwd = NK_ABSENT;
                n_next     = n_reg >> 1;
                lv_next    = lv_reg + 1'b1;
                state_next = S_FR_RD;
            end
            S_PUSH1:
            begin
                kwe = 1'b1; kwa = n_reg; kwd = NK_FREE;
                nwe = 1'b1; nwa = n_reg; nwd = head_rd;
                pwe = 1'b1; pwa = n_reg; pwd = '0;
                hwe = 1'b1; hwd = n_reg;
                h_next     = head_rd;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                if (h_reg != '0)
                begin
                    pwe = 1'b1; pwa = h_reg; pwd = n_reg;
                end
                if (item_reg.kind == REQ_REALLOC)
                begin
                    lv_next    = item_reg.want;
                    state_next = S_SRCH;
                end
                else
                    state_next = S_DONE;
            end
            S_SRCH:
            begin
                if (lv_reg > top_x)
                begin
                    rstat_next = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else if (head_rd != '0)
                begin
                    n_next     = head_rd;
                    state_next = S_LRD;
                end
                else
                    lv_next = lv_reg + 1'b1;
            end
            S_LRD:
            begin
                state_next = S_RM;
            end
            S_RM:
            begin
                if (prev_rd_reg == '0)
                begin
                    hwe = 1'b1;
                    hwd = next_rd_reg;
                end
                else
                begin
                    nwe = 1'b1; nwa = prev_rd_reg; nwd = next_rd_reg;
                end
                if (next_rd_reg != '0)
                begin
                    pwe = 1'b1; pwa = next_rd_reg; pwd = prev_rd_reg;
                end
                state_next = (lv_reg > item_reg.want) ? S_SP1 : S_BUSY;
            end
            S_SP1:
            begin
                // split: keep the left half, list the right half one level down
                kwe = 1'b1; kwa = n_reg; kwd = NK_INNER;
                nwe = 1'b1; nwa = {n_reg[NB-2:0], 1'b1}; nwd = head_rd;
                pwe = 1'b1; pwa = {n_reg[NB-2:0], 1'b1}; pwd = '0;
                hwe = 1'b1; hwd = {n_reg[NB-2:0], 1'b1};
                h_next     = head_rd;
                r_next     = {n_reg[NB-2:0], 1'b1};
                n_next     = {n_reg[NB-2:0], 1'b0};
                lv_next    = lv_reg - 1'b1;
                state_next = S_SP2;
            end
            S_SP2:
            begin
                kwe = 1'b1; kwa = r_reg; kwd = NK_FREE;
                if (h_reg != '0)
                begin
                    pwe = 1'b1; pwa = h_reg; pwd = r_reg;
                end
                state_next = (lv_reg > item_reg.want) ? S_SP1 : S_BUSY;
            end
            S_BUSY:
            begin
                kwe = 1'b1; kwa = n_reg; kwd = NK_BUSY;
                roff_next  = off_full[31:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = rstat_reg;
                    out_next.result_offset = (rstat_reg == ST_OK) ? roff_reg : '0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (restart)
        begin
            state_next = S_CLR;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SPLIT_DEPTH; i++)
                head_reg[i] <= '0;
        end
        else if (clr_init)
        begin
            // empty every list; the top level holds the root
            for (int i = 0; i <= SPLIT_DEPTH; i++)
                head_reg[i] <= (SW'(i) == slot_of(top_x, bot_x)) ? NB'(1) : '0;
        end
        else if (hwe)
            head_reg[hidx] <= hwd;
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        lv_reg    <= lv_next;
        base_reg  <= base_next;
        h_reg     <= h_next;
        r_reg     <= r_next;
        item_reg  <= item_next;
        roff_reg  <= roff_next;
        rstat_reg <= rstat_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (kwe)
            kind_mem[kwa] <= kwd;
        kind_rd_reg <= kind_mem[kaddr];
    end

    always_ff @(posedge clk)
    begin
        if (nwe)
            next_mem[nwa] <= nwd;
        if (pwe)
            prev_mem[pwa] <= pwd;
        next_rd_reg <= next_mem[laddr];
        prev_rd_reg <= prev_mem[laddr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && q_valid)
        else $error("queue popped outside idle");
    a_no_node0: assert property (@(posedge clk) disable iff (!rst_n)
        (kwe && state_reg != S_CLR) |-> (kwa != '0))
        else $error("node zero written after clear");
    a_walk_lv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FB_CHK) |-> (lv_reg >= bot_x) && (lv_reg <= top_x))
        else $error("tree walk left the level range");

endmodule

### design/buddy_suballocator.sv
// ----------------------------------------------------------------------------
// buddy_suballocator
// Binary buddy allocator handing out offsets within one power-of-two region.
// ----------------------------------------------------------------------------
// An alloc searches upward for a free block and splits it down; a free walks the
// tree to the block and merges it with free buddies; a realloc keeps the block if
// it is large enough, else frees it and allocates anew. The back takes one request
// at a time, while a two-entry queue in front takes requests until it is full.
// Reset and every register write start a clearing pass over all 2^(SPLIT_DEPTH+1)
// entries of the node table, after which only the root is a free leaf.
module buddy_suballocator
    import bsa_pkg::*;
#(
    parameter int SPLIT_DEPTH = 10,
    parameter int OFFSET_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  bsa_req_t    req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output bsa_rsp_t    rsp
);

    logic [5:0] whole_reg, whole_next;
    logic [5:0] min_reg, min_next;
    logic       wr_en;
    logic [5:0] ob;
    logic [5:0] top_lv;
    logic [5:0] bot_clamp;
    logic [5:0] bot_lv;
    logic       q_valid;
    logic       q_pop;
    bsa_item_t  q_item;

    // Register writes complete in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MIN) ? {26'd0, min_reg} : {26'd0, whole_reg};

    always_comb
    begin
        whole_next = whole_reg;
        min_next   = min_reg;
        if (wr_en)
        begin
            if (paddr[2] == REG_WHOLE)
                whole_next = pwdata[5:0];
            else
                min_next = pwdata[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg <= WHOLE_RESET;
            min_reg   <= MIN_RESET;
        end
        else
        begin
            whole_reg <= whole_next;
            min_reg   <= min_next;
        end
    end

    // Geometry: clamp the region to the offset width, the smallest block to
    // the region, then raise the smallest block so the tree fits its depth.
    assign ob        = 6'(OFFSET_BITS);
    assign top_lv    = (whole_reg > ob) ? ob : whole_reg;
    assign bot_clamp = (min_reg > top_lv) ? top_lv : min_reg;
    assign bot_lv    = ((top_lv - bot_clamp) > 6'(SPLIT_DEPTH))
                       ? (top_lv - 6'(SPLIT_DEPTH)) : bot_clamp;

    // Front: take request beats, compute the needed level, queue them.
    bsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bot_lv    (bot_lv),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Back: walk, split and merge the tree; a write restarts the clear pass.
    bsa_back #(
        .SPLIT_DEPTH (SPLIT_DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (wr_en),
        .top_lv    (top_lv),
        .bot_lv    (bot_lv),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
